// ===== sv/lbq_pkg.sv =====
// ----------------------------------------------------------------------------
// lbq_pkg
// Shared types and constants for the linked block queue with free list.
// ----------------------------------------------------------------------------
`default_nettype none

package lbq_pkg;

  localparam int DEF_POOL_NODES = 16;
  localparam int BSIZE_W        = 16;
  localparam int OFFSET_W       = 20;
  localparam int KIND_W         = 2;

  localparam logic [BSIZE_W-1:0] DEF_BLOCK_SIZE = 16'd64;

  typedef enum logic [KIND_W-1:0] {
    KIND_ALLOC   = 2'd0,
    KIND_COMMIT  = 2'd1,
    KIND_READ    = 2'd2,
    KIND_RELEASE = 2'd3
  } kind_t;

  // free list operation, applied in the execute cycle
  typedef struct packed {
    logic pop;
    logic push;
  } free_op_t;

endpackage

`default_nettype wire

// ===== sv/lbq_free_list.sv =====
// ----------------------------------------------------------------------------
// lbq_free_list
// Free node stack: link memory, top pointer, free count, init sweep.
// ----------------------------------------------------------------------------
`default_nettype none

module lbq_free_list #(
  parameter int POOL_NODES = lbq_pkg::DEF_POOL_NODES
) (
  input  wire                                  clk,
  input  wire                                  rst,
  input  wire lbq_pkg::free_op_t               op,
  input  wire [$clog2(POOL_NODES)-1:0]         push_node,
  output logic                                 ready,
  output logic                                 top_valid,
  output logic [$clog2(POOL_NODES)-1:0]        top_node,
  output logic [$clog2(POOL_NODES+1)-1:0]      in_use
);

  localparam int NODE_W = $clog2(POOL_NODES);
  localparam int CNT_W  = $clog2(POOL_NODES + 1);
  localparam logic [NODE_W-1:0] LAST_NODE = NODE_W'(POOL_NODES - 1);
  localparam logic [CNT_W-1:0]  FULL_CNT  = CNT_W'(POOL_NODES);

  // entry: valid in the top bit, next node below
  logic [NODE_W:0]   link_mem [POOL_NODES];
  logic [NODE_W:0]   link_rd;
  logic              clearing;
  logic [NODE_W-1:0] clr_idx;
  logic [NODE_W-1:0] clr_next;
  logic [CNT_W-1:0]  free_count;

  assign clr_next = NODE_W'(clr_idx + 1'b1);

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing   <= 1'b1;
      clr_idx    <= '0;
      top_valid  <= 1'b1;
      top_node   <= NODE_W'(1);
      free_count <= CNT_W'(POOL_NODES - 1);
    end else if (clearing) begin
      if (clr_idx == LAST_NODE) begin
        clearing <= 1'b0;
      end
      clr_idx <= clr_next;
    end else if (op.pop) begin
      top_valid <= link_rd[NODE_W];
      top_node  <= link_rd[NODE_W-1:0];
      if (free_count != '0) begin
        free_count <= free_count - 1'b1;
      end
    end else if (op.push) begin
      top_valid <= 1'b1;
      top_node  <= push_node;
      if (free_count != FULL_CNT) begin
        free_count <= free_count + 1'b1;
      end
    end
  end

  // link memory: one write port, registered read at the top node
  always_ff @(posedge clk) begin
    if (clearing) begin
      if (clr_idx == LAST_NODE) begin
        link_mem[clr_idx] <= '0;
      end else begin
        link_mem[clr_idx] <= {1'b1, clr_next};
      end
    end else if (op.push) begin
      link_mem[push_node] <= {top_valid, top_node};
    end
    link_rd <= link_mem[top_node];
  end

  assign ready  = !clearing;
  assign in_use = FULL_CNT - free_count;

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    free_count <= FULL_CNT)
    else $error("free count above pool size");

  a_sweep_end: assert property (@(posedge clk) disable iff (rst)
    $fell(clearing) |-> $past(clr_idx) == LAST_NODE)
    else $error("init sweep ended early");

  a_no_op_in_sweep: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !op.pop && !op.push)
    else $error("free list operation during init sweep");

endmodule

`default_nettype wire

// ===== sv/linked_block_queue_with_free_list.sv =====
// ----------------------------------------------------------------------------
// linked_block_queue_with_free_list
// Buffer manager for a pool of blocks: free node stack plus linked FIFO
// with a dummy front node.
// ----------------------------------------------------------------------------
//
//  Channel   Signals                                   Transfer when
//  --------  ----------------------------------------  ------------------
//  request   start, busy, kind, node_index             start && !busy
//  result    done, ok, data_index, release_index,      done (one cycle)
//            block_offset, in_use
//  config    cfg_wr_en, cfg_wr_data (block_size)       cfg_wr_en
//
//  An item is accepted in IDLE and executed in EXEC: the accept cycle
//  reads both link memories (registered reads), the execute cycle
//  updates them and the pointers. The result strobes in the cycle after
//  that, alongside the next accept; no new item is taken during EXEC.
//  After reset the free link memory is initialised by a sweep over all
//  POOL_NODES entries; busy stays high throughout.
//  The receiver cannot stall; nothing is held back on the result side.
// ----------------------------------------------------------------------------
`default_nettype none

module linked_block_queue_with_free_list #(
  parameter int POOL_NODES = lbq_pkg::DEF_POOL_NODES
) (
  input  wire                                     clk,
  input  wire                                     rst,
  input  wire                                     start,
  output logic                                    busy,
  input  wire  [lbq_pkg::KIND_W-1:0]              kind,
  input  wire  [$clog2(POOL_NODES)-1:0]           node_index,
  input  wire                                     cfg_wr_en,
  input  wire  [lbq_pkg::BSIZE_W-1:0]             cfg_wr_data,
  output logic                                    done,
  output logic                                    ok,
  output logic [$clog2(POOL_NODES)-1:0]           data_index,
  output logic [$clog2(POOL_NODES)-1:0]           release_index,
  output logic [lbq_pkg::OFFSET_W-1:0]            block_offset,
  output logic [$clog2(POOL_NODES+1)-1:0]         in_use
);

  localparam int NODE_W = $clog2(POOL_NODES);
  localparam logic [NODE_W:0] NODE_LIMIT = (NODE_W + 1)'(POOL_NODES);

  typedef enum logic {
    IDLE,
    EXEC
  } state_t;

  state_t                      state;
  lbq_pkg::kind_t              kind_q;
  logic [NODE_W-1:0]           node_q;
  logic [NODE_W-1:0]           front;
  logic [NODE_W-1:0]           back;
  logic [lbq_pkg::BSIZE_W-1:0] block_size;

  // queue links hold the next node only: a path of written links always
  // runs from front to back, so an entry is never read before it is written
  logic [NODE_W-1:0]           qlink_mem [POOL_NODES];
  logic [NODE_W-1:0]           qlink_rd;

  logic                        fl_ready;
  logic                        fl_top_valid;
  logic [NODE_W-1:0]           fl_top_node;
  lbq_pkg::free_op_t           fl_op;

  logic                        accept;
  logic                        in_range;
  logic                        ok_c;
  logic [NODE_W-1:0]           data_c;
  logic [NODE_W-1:0]           rel_c;
  logic                        qwr_en;
  logic [NODE_W+lbq_pkg::BSIZE_W-1:0] product;

  assign busy     = (state == EXEC) || !fl_ready;
  assign accept   = start && !busy;
  assign in_range = {1'b0, node_q} < NODE_LIMIT;

  // execute-cycle decision
  always_comb begin
    ok_c   = 1'b0;
    data_c = '0;
    rel_c  = '0;
    qwr_en = 1'b0;
    fl_op  = '0;
    if (state == EXEC) begin
      unique case (kind_q)
        lbq_pkg::KIND_ALLOC: begin
          if (fl_top_valid) begin
            ok_c      = 1'b1;
            data_c    = fl_top_node;
            fl_op.pop = 1'b1;
          end
        end
        lbq_pkg::KIND_COMMIT: begin
          if (in_range) begin
            ok_c   = 1'b1;
            qwr_en = 1'b1;
          end
        end
        lbq_pkg::KIND_READ: begin
          if (front != back) begin
            ok_c   = 1'b1;
            data_c = qlink_rd;
            rel_c  = front;
          end
        end
        lbq_pkg::KIND_RELEASE: begin
          if (in_range) begin
            ok_c       = 1'b1;
            fl_op.push = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  assign product = data_c * block_size;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= IDLE;
      done       <= 1'b0;
      front      <= '0;
      back       <= '0;
      block_size <= lbq_pkg::DEF_BLOCK_SIZE;
    end else begin
      done <= 1'b0;
      if (cfg_wr_en) begin
        block_size <= cfg_wr_data;
      end
      unique case (state)
        IDLE: begin
          if (accept) begin
            state <= EXEC;
          end
        end
        EXEC: begin
          state <= IDLE;
          done  <= 1'b1;
          if (qwr_en) begin
            back <= node_q;
          end
          if (ok_c && kind_q == lbq_pkg::KIND_READ) begin
            front <= qlink_rd;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  // request and result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      kind_q <= lbq_pkg::kind_t'(kind);
      node_q <= node_index;
    end
    if (state == EXEC) begin
      ok            <= ok_c;
      data_index    <= data_c;
      release_index <= rel_c;
      block_offset  <= lbq_pkg::OFFSET_W'(product);
    end
  end

  // queue link memory: back links to the committed node
  always_ff @(posedge clk) begin
    if (qwr_en) begin
      qlink_mem[back] <= node_q;
    end
    qlink_rd <= qlink_mem[front];
  end

  lbq_free_list #(
    .POOL_NODES (POOL_NODES)
  ) u_free (
    .clk       (clk),
    .rst       (rst),
    .op        (fl_op),
    .push_node (node_q),
    .ready     (fl_ready),
    .top_valid (fl_top_valid),
    .top_node  (fl_top_node),
    .in_use    (in_use)
  );

  a_exec_once: assert property (@(posedge clk) disable iff (rst)
    state == EXEC |=> state == IDLE && done)
    else $error("execute cycle not followed by result");

  a_done_src: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == EXEC))
    else $error("result without execute cycle");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    done && !ok |-> data_index == '0 && release_index == '0 && block_offset == '0)
    else $error("failed transfer carries data");

  a_read_adv: assert property (@(posedge clk) disable iff (rst)
    state == EXEC && kind_q == lbq_pkg::KIND_READ && front != back
      |=> front == $past(qlink_rd) && release_index == $past(front))
    else $error("front not advanced on read");

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the linked block queue with free list: a driver
// feeds allocate, commit, read and release requests with random hold-offs,
// a behavioural model predicts every result, and a monitor checks each
// result strobe field by field across several block sizes.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import lbq_pkg::*;

  localparam int NODES          = DEF_POOL_NODES;
  localparam int IDX_W          = $clog2(NODES);
  localparam int CNT_W          = $clog2(NODES + 1);
  localparam int MAX_GAP        = 12;
  localparam int SETTLE_CYCLES  = 4;
  localparam int WATCHDOG_LIMIT = 1000;  // idle cycles tolerated

  // Pool bookkeeping as the block sees it; each link is a valid bit plus a node
  typedef struct packed {
    logic [NODES-1:0]            q_valid;
    logic [NODES-1:0][IDX_W-1:0] q_next;
    logic [NODES-1:0]            f_valid;
    logic [NODES-1:0][IDX_W-1:0] f_next;
    logic                        top_valid;
    logic [IDX_W-1:0]            top_node;
    logic [IDX_W-1:0]            front;     // dummy node of the FIFO
    logic [IDX_W-1:0]            back;
    logic [CNT_W-1:0]            spare;     // nodes sitting on the free list
  } pool_t;

  // One result, in port order
  typedef struct packed {
    logic                ok;
    logic [IDX_W-1:0]    data;
    logic [IDX_W-1:0]    rel;
    logic [OFFSET_W-1:0] offset;
    logic [CNT_W-1:0]    used;
  } outcome_t;

  typedef struct {
    kind_t            kind;
    logic [IDX_W-1:0] node;
    int unsigned      gap;    // idle cycles ahead of this request
    bit               drain;  // hold until every outstanding result is back
  } request_t;

  // --------------------------------------------------------------------------
  // DUT hookup; every input starts at a known value
  // --------------------------------------------------------------------------
  logic                 clk;
  logic                 rst         = 1'b1;
  logic                 start       = 1'b0;
  kind_t                req_kind    = KIND_ALLOC;
  logic [IDX_W-1:0]     req_node    = '0;
  logic                 cfg_wr_en   = 1'b0;
  logic [BSIZE_W-1:0]   cfg_wr_data = '0;
  wire                  busy;
  wire                  done;
  wire                  ok;
  wire  [IDX_W-1:0]     data_index;
  wire  [IDX_W-1:0]     release_index;
  wire  [OFFSET_W-1:0]  block_offset;
  wire  [CNT_W-1:0]     in_use;

  linked_block_queue_with_free_list dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .kind          (req_kind),
    .node_index    (req_node),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .done          (done),
    .ok            (ok),
    .data_index    (data_index),
    .release_index (release_index),
    .block_offset  (block_offset),
    .in_use        (in_use)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // --------------------------------------------------------------------------
  // Shared bench state
  // --------------------------------------------------------------------------
  request_t           pending[$];     // requests not yet presented
  outcome_t           results_due[$]; // predicted results, oldest first
  pool_t              pool;           // checking copy, stepped at each transfer
  pool_t              shadow;         // generator copy, stepped as requests are queued
  logic [BSIZE_W-1:0] blk_bytes;      // block size the checking copy assumes
  logic [NODES-1:0]   held_alloc;     // allocated, not yet committed
  logic [NODES-1:0]   held_rel;       // old dummies owed a release
  outcome_t           staged;         // prediction for the last transfer
  logic               staged_vld = 1'b0;
  outcome_t           predicted;
  outcome_t           seen;
  outcome_t           want;
  request_t           nxt;
  int unsigned        hold_off   = 0;
  int unsigned        n_accepted = 0;
  int unsigned        n_results  = 0;
  int unsigned        quiet      = 0;
  int unsigned        errors     = 0;
  int unsigned        kind_cnt[4];
  int unsigned        n_exhausted;
  int unsigned        n_empty;
  logic [BSIZE_W-1:0] size_a;
  logic [BSIZE_W-1:0] size_b;

  // State straight out of reset: node 0 is the dummy, 1..15 chained as free
  function automatic pool_t fresh_pool();
    pool_t p;
    p = '0;
    for (int i = 0; i < NODES - 1; i++) begin
      p.f_valid[i] = 1'b1;
      p.f_next[i]  = IDX_W'(i + 1);
    end
    p.top_valid = 1'b1;
    p.top_node  = IDX_W'(1);
    p.spare     = CNT_W'(NODES - 1);
    return p;
  endfunction

  // Serves one request against a pool and returns the result it should give
  function automatic outcome_t serve(inout pool_t p, input kind_t k,
                                     input logic [IDX_W-1:0] n,
                                     input logic [BSIZE_W-1:0] bsz);
    outcome_t r;
    r = '0;
    case (k)
      KIND_ALLOC: begin
        // empty pool: nothing moves
        if (p.top_valid) begin
          r.ok        = 1'b1;
          r.data      = p.top_node;
          p.top_valid = p.f_valid[r.data];
          p.top_node  = p.f_next[r.data];
          if (p.spare != 0) p.spare = p.spare - 1'b1;
        end
      end
      KIND_COMMIT: begin
        // order matters when the node is already the back: self link
        p.q_valid[n]      = 1'b0;
        p.q_next[n]       = '0;
        p.q_valid[p.back] = 1'b1;
        p.q_next[p.back]  = n;
        p.back            = n;
        r.ok              = 1'b1;
      end
      KIND_READ: begin
        if (p.front != p.back && p.q_valid[p.front]) begin
          r.ok    = 1'b1;
          r.rel   = p.front;
          r.data  = p.q_next[p.front];
          p.front = r.data;
        end
      end
      default: begin
        // release: plain push, double release not guarded
        p.f_valid[n] = p.top_valid;
        p.f_next[n]  = p.top_node;
        p.top_valid  = 1'b1;
        p.top_node   = n;
        if (p.spare < NODES) p.spare = p.spare + 1'b1;
        r.ok         = 1'b1;
      end
    endcase
    r.offset = OFFSET_W'(32'(r.data) * 32'(bsz));
    r.used   = CNT_W'(NODES - p.spare);
    return r;
  endfunction

  function automatic void check_field(string what, int unsigned exp_v, int unsigned act_v);
    if (exp_v != act_v) begin
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, what, exp_v, act_v);
      errors++;
    end
  endfunction

  // Random node out of a mask; 0 if the mask is empty
  function automatic logic [IDX_W-1:0] pick_node(logic [NODES-1:0] mask);
    int base;
    int j;
    base = $urandom_range(0, NODES - 1);
    for (int i = 0; i < NODES; i++) begin
      j = (base + i) % NODES;
      if (mask[j]) return IDX_W'(j);
    end
    return '0;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus generation: the shadow pool tells which nodes the bench owns,
  // so well-formed sequences commit what was allocated and release what
  // reads handed back.
  // --------------------------------------------------------------------------
  task automatic add_req(input kind_t k, input logic [IDX_W-1:0] n,
                         input int unsigned gap, input bit drain);
    outcome_t o;
    request_t r;
    o = serve(shadow, k, n, '0);
    case (k)
      KIND_ALLOC:  if (o.ok) held_alloc[o.data] = 1'b1;
      KIND_COMMIT: held_alloc[n] = 1'b0;
      KIND_READ:   if (o.ok) held_rel[o.rel] = 1'b1;
      default:     held_rel[n] = 1'b0;
    endcase
    r.kind  = k;
    r.node  = n;
    r.gap   = gap;
    r.drain = drain;
    pending.push_back(r);
  endtask

  // Idle stretches alternate with back-to-back runs
  function automatic int unsigned draw_gap(int i);
    return ((i / 60) % 3 == 1) ? 0 : $urandom_range(0, MAX_GAP);
  endfunction

  task automatic fill_phase(input int count, input int noise_pct);
    int unsigned      r;
    int unsigned      gap;
    bit               drain;
    logic [IDX_W-1:0] junk;
    for (int i = 0; i < count; i++) begin
      r     = $urandom_range(0, 99);
      gap   = draw_gap(i);
      drain = ($urandom_range(0, 99) == 0);
      junk  = IDX_W'($urandom_range(0, NODES - 1));  // random content; ignored by allocate and read
      if ($urandom_range(0, 99) < noise_pct)
        add_req(kind_t'(KIND_W'($urandom_range(0, 3))), junk, gap, drain);
      else if (r < 28 || (r < 52 && held_alloc == '0))
        add_req(KIND_ALLOC, junk, gap, drain);
      else if (r < 52)
        add_req(KIND_COMMIT, pick_node(held_alloc), gap, drain);
      else if (r < 76 || held_rel == '0)
        add_req(KIND_READ, junk, gap, drain);
      else
        add_req(KIND_RELEASE, pick_node(held_rel), gap, drain);
    end
  endtask

  // Sampled on the falling edge so nothing races the clocked blocks
  task automatic wait_idle();
    do @(negedge clk);
    while (pending.size() != 0 || start || n_results != n_accepted);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_block_size(input logic [BSIZE_W-1:0] v);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    blk_bytes   = v;
    @(negedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Sequencer: directed opening at the reset block size, then random phases
  // at 65535, 1 and two random sizes. Each phase boundary lets every result
  // drain before the register is touched.
  // --------------------------------------------------------------------------
  initial begin
    pool       = fresh_pool();
    shadow     = fresh_pool();
    blk_bytes  = DEF_BLOCK_SIZE;
    held_alloc = '0;
    held_rel   = '0;
    size_a     = BSIZE_W'($urandom_range(1, 65535));
    size_b     = BSIZE_W'($urandom_range(1, 65535));

    // Directed: empty-queue read, drain the pool, exhausted allocate,
    // commit of extreme nodes, recommit of the back node, reads to empty,
    // then release of both old dummies.
    add_req(KIND_READ, IDX_W'($urandom), 0, 1'b0);
    for (int i = 0; i < NODES - 1; i++)
      add_req(KIND_ALLOC, IDX_W'($urandom), draw_gap(i * 7), 1'b0);
    add_req(KIND_ALLOC, '1, 0, 1'b0);
    add_req(KIND_COMMIT, IDX_W'(NODES - 1), 0, 1'b0);
    add_req(KIND_COMMIT, IDX_W'(1), $urandom_range(0, MAX_GAP), 1'b0);
    add_req(KIND_COMMIT, IDX_W'(1), 0, 1'b0);
    add_req(KIND_READ, '0, 0, 1'b0);
    add_req(KIND_READ, '1, $urandom_range(0, MAX_GAP), 1'b0);
    add_req(KIND_READ, '0, 0, 1'b1);
    add_req(KIND_RELEASE, '0, 0, 1'b0);
    add_req(KIND_RELEASE, IDX_W'(NODES - 1), 0, 1'b0);

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    wait_idle();

    set_block_size('1);
    fill_phase(350, 0);
    wait_idle();

    set_block_size(BSIZE_W'(1));
    fill_phase(350, 0);
    wait_idle();

    set_block_size(size_a);
    fill_phase(300, 0);
    wait_idle();

    // Last phase: stray commits and releases break the lists for good,
    // so they come at the end; a run of releases drives the count to
    // saturation.
    set_block_size(size_b);
    fill_phase(280, 30);
    for (int i = 0; i < NODES + 2; i++)
      add_req(KIND_RELEASE, IDX_W'($urandom_range(0, NODES - 1)), draw_gap(i), 1'b0);
    wait_idle();

    if (results_due.size() != 0) begin
      $display("%0t ns: %0d expected results never arrived", $time, results_due.size());
      errors++;
    end
    $display("Covered %0d requests: %0d allocate (%0d on an exhausted pool), %0d commit,",
             n_accepted, kind_cnt[KIND_ALLOC], n_exhausted, kind_cnt[KIND_COMMIT]);
    $display("  %0d read (%0d on an empty queue), %0d release; block sizes 64 65535 1 %0d %0d",
             kind_cnt[KIND_READ], n_empty, kind_cnt[KIND_RELEASE], size_a, size_b);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // Driver: a transfer happens at an edge with start high and busy low.
  // The prediction is made right there and staged in a register for the
  // monitor, which queues it well ahead of the result.
  // start stays high across back-to-back transfers rather than dropping.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      start      <= 1'b0;
      staged_vld <= 1'b0;
      hold_off   <= 0;
    end else begin
      staged_vld <= start && !busy;
      if (start && !busy) begin
        predicted = serve(pool, req_kind, req_node, blk_bytes);
        staged     <= predicted;
        n_accepted <= n_accepted + 1;
        kind_cnt[req_kind]++;
        if (req_kind == KIND_ALLOC && !predicted.ok) n_exhausted++;
        if (req_kind == KIND_READ && !predicted.ok) n_empty++;
        if (pending.size() != 0 && pending[0].gap == 0 && !pending[0].drain) begin
          nxt = pending.pop_front();
          req_kind <= nxt.kind;
          req_node <= nxt.node;
        end else begin
          start    <= 1'b0;
          hold_off <= (pending.size() != 0) ? pending[0].gap : 0;
        end
      end else if (!start) begin
        if (hold_off != 0) begin
          hold_off <= hold_off - 1;
        end else if (pending.size() != 0 &&
                     (!pending[0].drain || n_results == n_accepted)) begin
          nxt = pending.pop_front();
          start    <= 1'b1;
          req_kind <= nxt.kind;
          req_node <= nxt.node;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: the sole owner of the expectation queue. Staged predictions go
  // in first, then a strobed result is matched against the oldest entry.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst) begin
      if (staged_vld) results_due.push_back(staged);
      if (done) begin
        n_results <= n_results + 1;
        seen = {ok, data_index, release_index, block_offset, in_use};
        if (results_due.size() == 0) begin
          $display("%0t ns: result with nothing outstanding, got ok=%0d data=%0d",
                   $time, seen.ok, seen.data);
          errors++;
        end else begin
          want = results_due.pop_front();
          check_field("ok",            want.ok,     seen.ok);
          check_field("data_index",    want.data,   seen.data);
          check_field("release_index", want.rel,    seen.rel);
          check_field("block_offset",  want.offset, seen.offset);
          check_field("in_use",        want.used,   seen.used);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: any long stretch without a request or result transfer is a hang
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      quiet <= 0;
    end else if (quiet == WATCHDOG_LIMIT) begin
      $display("%0t ns: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

endmodule

`default_nettype wire

// ===== linked_block_queue_with_free_list.f =====
sv/lbq_pkg.sv
sv/lbq_free_list.sv
sv/linked_block_queue_with_free_list.sv
bench/testbench.sv
